>>> src/battery_led_bar_animator_top_defines.svh
// ----------------------------------------------------------------------------
// Battery LED bar animator - assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LED_BAR_ANIMATOR_TOP_DEFINES_SVH
`define BATTERY_LED_BAR_ANIMATOR_TOP_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define BLA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the same edge
`define BLA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante at one edge implies cons at the next edge
`define BLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bla_pkg.sv
// ----------------------------------------------------------------------------
// Battery LED bar animator package
// Types, event codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bla_pkg;

    localparam int LED_COUNT = 5;
    localparam int LEVEL_STEP = 100 / LED_COUNT;

    localparam int STARTUP_ON_MS = 500;
    localparam int STARTUP_END_MS = 1000;

    typedef logic [LED_COUNT-1:0] led_t;

    localparam led_t CRIT_PAT_A = led_t'(8'h0A);
    localparam led_t CRIT_PAT_B = led_t'(8'h15);
    localparam led_t LOW_LED = led_t'(8'h01);

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_LEVEL    = 3'd1,
        MODE_CHARGING = 3'd2,
        MODE_CRITICAL = 3'd3,
        MODE_EMPTY    = 3'd4,
        MODE_NUMBER   = 3'd5,
        MODE_STARTUP  = 3'd6
    } mode_e;

    typedef enum logic [1:0] {
        CFG_CHARGE_STEP   = 2'd0,
        CFG_EMPTY_STEP    = 2'd1,
        CFG_CRITICAL_GAP  = 2'd2,
        CFG_CRITICAL_BLINK = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [15:0] charge_step_ms;
        logic [15:0] empty_step_ms;
        logic [15:0] critical_gap_ms;
        logic [15:0] critical_blink_ms;
    } cfg_t;

    typedef struct packed {
        logic        level_mode;
        logic [2:0]  anim_step;
        logic [15:0] anim_elapsed;
        logic [15:0] critical_elapsed;
        logic        startup_active;
        logic [10:0] startup_elapsed;
        logic [7:0]  charge_level;
        logic [7:0]  shown_number;
        logic        charging_on;
        logic        critical_on;
        logic        empty_on;
        led_t        last_pattern;
    } state_t;

endpackage

`default_nettype wire

>>> src/bla_update.sv
// ----------------------------------------------------------------------------
// Battery LED bar animator - event and display update
// Applies one event to the display state and works out the new pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_update (
    input  bla_pkg::state_t    state_i,
    input  bla_pkg::cfg_t      cfg_i,
    input  logic [2:0]         mode_i,
    input  logic [7:0]         value_i,
    output bla_pkg::state_t    state_o
);
    import bla_pkg::*;

    state_t      st;
    led_t        bars;
    logic [2:0]  step_inc;
    logic [15:0] crit_wait;

    always_comb begin
        st = state_i;
        bars = '0;
        step_inc = '0;
        crit_wait = '0;

        // event
        unique case (mode_i)
            MODE_TICK: begin
                if (st.anim_elapsed != '1) st.anim_elapsed = st.anim_elapsed + 16'd1;
                if (st.critical_elapsed != '1) begin
                    st.critical_elapsed = st.critical_elapsed + 16'd1;
                end
                if (st.startup_elapsed != '1) begin
                    st.startup_elapsed = st.startup_elapsed + 11'd1;
                end
            end
            MODE_LEVEL: begin
                if (!st.level_mode) begin
                    st.level_mode = 1'b1;
                    st.anim_step = '0;
                    st.anim_elapsed = '0;
                end
                st.charge_level = value_i;
            end
            MODE_CHARGING: begin
                st.charging_on = value_i[0];
                st.anim_step = '0;
                st.anim_elapsed = '0;
            end
            MODE_CRITICAL: begin
                st.critical_on = value_i[0];
                st.anim_step = '0;
                st.anim_elapsed = '0;
            end
            MODE_EMPTY: begin
                st.empty_on = value_i[0];
                st.anim_step = '0;
                st.anim_elapsed = '0;
            end
            MODE_NUMBER: begin
                st.shown_number = value_i;
                st.level_mode = 1'b0;
                st.anim_step = '0;
                st.anim_elapsed = '0;
            end
            MODE_STARTUP: begin
                st.startup_active = 1'b1;
                st.startup_elapsed = '0;
            end
            default: begin
            end
        endcase

        // display
        if (st.startup_active) begin
            if (st.startup_elapsed > 11'(STARTUP_END_MS)) begin
                // sequence over: pattern left as it was for this transaction
                st.startup_active = 1'b0;
            end else if (st.startup_elapsed > 11'(STARTUP_ON_MS)) begin
                st.last_pattern = '0;
            end else begin
                st.last_pattern = '1;
            end
        end else if (st.level_mode) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                bars[i] = st.charge_level > 8'(i * LEVEL_STEP);
            end

            if (st.charging_on) begin
                if (st.anim_elapsed > cfg_i.charge_step_ms) begin
                    step_inc = st.anim_step + 3'd1;
                    st.anim_step = (step_inc == 3'(LED_COUNT + 1)) ? 3'd0 : step_inc;
                    st.anim_elapsed = '0;
                end
                // thermometer mask; the step at the bar width shows the whole level bar
                bars = (bars | LOW_LED) & led_t'((8'd1 << st.anim_step) - 8'd1);
            end else if (st.empty_on) begin
                if (st.anim_elapsed > cfg_i.empty_step_ms) begin
                    st.anim_step = (st.anim_step == 3'd0) ? 3'd1 : 3'd0;
                    st.anim_elapsed = '0;
                end
                bars = (st.anim_step == 3'd0) ? led_t'(0) : (bars | LOW_LED);
            end

            if (st.critical_on && st.anim_step <= 3'd4) begin
                crit_wait = (st.anim_step == 3'd0) ? cfg_i.critical_gap_ms
                                                   : cfg_i.critical_blink_ms;
                if (st.anim_step == 3'd1 || st.anim_step == 3'd3) begin
                    bars = CRIT_PAT_A;
                end else if (st.anim_step == 3'd2 || st.anim_step == 3'd4) begin
                    bars = CRIT_PAT_B;
                end
                if (st.critical_elapsed > crit_wait) begin
                    st.anim_step = (st.anim_step == 3'd4) ? 3'd0 : st.anim_step + 3'd1;
                    st.critical_elapsed = '0;
                end
            end
            st.last_pattern = bars;
        end else begin
            st.last_pattern = st.shown_number[LED_COUNT-1:0];
        end
    end

    assign state_o = st;

endmodule

`default_nettype wire

>>> src/battery_led_bar_animator_top.sv
// ----------------------------------------------------------------------------
// Battery LED bar animator - top level
// Five-LED charge bar driven by tick, level, flag, number and power-up events.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_mode[2:0], s_value[7:0]
//  m_       out        m_valid/m_ready    m_leds[4:0], m_in_startup
//  cfg_     in         cfg_wr_en          cfg_index[1:0], cfg_wdata[15:0]
//
//  One result transaction per input transaction. One transaction per cycle
//  sustained while the m_ side does not stall: input register, then one pass of the
//  update logic into the state register, whose pattern drives the m_ port.
//  Synchronous active-low reset restores state_reg, valid flags, cfg defaults.
//  A stalled m_ side holds the result; s_ready still takes one more
//  transaction into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_led_bar_animator_top_defines.svh"

module battery_led_bar_animator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_mode,
    input  logic [7:0]                   s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bla_pkg::LED_COUNT-1:0] m_leds,
    output logic                         m_in_startup
);
    import bla_pkg::*;

    cfg_t       cfg_reg;
    logic       in_vld_reg;
    logic [2:0] in_mode_reg;
    logic [7:0] in_value_reg;
    logic       out_vld_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       pipe_adv;
    logic       step_en;

    assign pipe_adv = !out_vld_reg || m_ready;
    assign step_en  = in_vld_reg && pipe_adv;
    assign s_ready  = !in_vld_reg || pipe_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_step_ms    <= 16'd200;
            cfg_reg.empty_step_ms     <= 16'd500;
            cfg_reg.critical_gap_ms   <= 16'd1000;
            cfg_reg.critical_blink_ms <= 16'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_CHARGE_STEP:    cfg_reg.charge_step_ms    <= cfg_wdata;
                CFG_EMPTY_STEP:     cfg_reg.empty_step_ms     <= cfg_wdata;
                CFG_CRITICAL_GAP:   cfg_reg.critical_gap_ms   <= cfg_wdata;
                CFG_CRITICAL_BLINK: cfg_reg.critical_blink_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= s_mode;
            in_value_reg <= s_value;
        end
    end

    bla_update u_update (
        .state_i (state_reg),
        .cfg_i   (cfg_reg),
        .mode_i  (in_mode_reg),
        .value_i (in_value_reg),
        .state_o (state_next)
    );

    // the state register doubles as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (pipe_adv) out_vld_reg <= in_vld_reg;
            if (step_en) state_reg <= state_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_leds       = state_reg.last_pattern;
    assign m_in_startup = state_reg.startup_active;

    `BLA_ASSERT_HOLDS(a_step_range, state_reg.anim_step <= 3'(LED_COUNT), "anim_step out of range")
    `BLA_ASSERT_IMPLIES(a_startup_bound, state_reg.startup_active, state_reg.startup_elapsed <= 11'(STARTUP_END_MS), "power-up still active past its end")
    `BLA_ASSERT_NEXT(a_state_hold, !step_en, $stable(state_reg), "state moved without a transaction")
    `BLA_ASSERT_NEXT(a_in_hold, in_vld_reg && !pipe_adv, in_vld_reg && $stable(in_mode_reg) && $stable(in_value_reg), "input register lost a stalled transaction")

endmodule

`default_nettype wire
